// ----- hw/rtl/ddpi_pkg.sv -----
// Shared types and constants for the differential drive PI speed controller.
// No dependencies; imported by the steering block, the wheel lanes and the top level.
`default_nettype none

package ddpi_pkg;

  typedef enum logic [1:0] {
    FN_SET   = 2'd0,
    FN_REG   = 2'd1,
    FN_STOP  = 2'd2,
    FN_START = 2'd3
  } func_t;

  // configuration register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_SPEED_LIMIT = 3'd0;
  localparam logic [2:0] REG_PWM_SCALE   = 3'd1;
  localparam logic [2:0] REG_PROP_GAIN   = 3'd2;
  localparam logic [2:0] REG_INTEG_GAIN  = 3'd3;
  localparam logic [2:0] REG_ERR_THRESH  = 3'd4;
  localparam logic [2:0] REG_GAIN_FAST   = 3'd5;
  localparam logic [2:0] REG_GAIN_SLOW   = 3'd6;
  localparam logic [2:0] REG_ANGLE_LIMIT = 3'd7;

  localparam logic [14:0] SPLIT_SPEED = 15'd1800;

  // step strobes and decoded command, from the sequencer to the datapath blocks
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic do_set;
    logic do_reg;
    logic do_clear;
  } ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/differential_drive_pi_speed_control.sv -----
// Differential drive PI speed controller, top level: APB register file,
// step sequencer, steering stage, two wheel lanes and the output register.
// An item is accepted only when idle, then passes four datapath steps and the output
// load, which waits while a held result is not taken; a new item is accepted only
// after that load, as set by the chained multiplies of the steering stage and lanes.
// Reset (rst_n low, synchronous): registers to defaults, state cleared, motors off.
`default_nettype none

module differential_drive_pi_speed_control (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_func,
  input  logic signed [15:0]  in_speed,
  input  logic signed [15:0]  in_angle,
  input  logic signed [15:0]  in_enc_left,
  input  logic signed [15:0]  in_enc_right,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  out_servo_angle,
  output logic [15:0]         out_pwm_left,
  output logic [15:0]         out_pwm_right,
  output logic                out_motors_on,
  output logic [14:0]         out_seen_left,
  output logic [14:0]         out_seen_right,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import ddpi_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_S1   = 6'b000010,
    ST_S2   = 6'b000100,
    ST_S3   = 6'b001000,
    ST_S4   = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [14:0] speed_limit_r, err_thresh_r, angle_limit_r;
  logic [15:0] pwm_scale_r, prop_gain_r, integ_gain_r, gain_fast_r, gain_slow_r;

  func_t              func_r;
  logic signed [15:0] speed_r, angle_r, encl_r, encr_r;
  logic               drive_en_r;

  logic signed [15:0] out_angle_r;
  logic [15:0]        out_pwml_r, out_pwmr_r;
  logic               out_mot_r;
  logic [14:0]        out_seenl_r, out_seenr_r;
  logic               out_valid_r;

  ctl_t               ctl;
  logic               in_xfer, cfg_wr, out_load;
  logic signed [15:0] steer_angle;
  logic signed [17:0] target_left, target_right;
  logic [14:0]        act_left, act_right;
  logic [15:0]        pwm_left, pwm_right;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_limit_r <= 15'd32767;
      pwm_scale_r   <= 16'd256;
      prop_gain_r   <= '0;
      integ_gain_r  <= '0;
      err_thresh_r  <= '0;
      gain_fast_r   <= '0;
      gain_slow_r   <= '0;
      angle_limit_r <= 15'd7680;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_SPEED_LIMIT: speed_limit_r <= pwdata[14:0];
        REG_PWM_SCALE:   pwm_scale_r   <= pwdata[15:0];
        REG_PROP_GAIN:   prop_gain_r   <= pwdata[15:0];
        REG_INTEG_GAIN:  integ_gain_r  <= pwdata[15:0];
        REG_ERR_THRESH:  err_thresh_r  <= pwdata[14:0];
        REG_GAIN_FAST:   gain_fast_r   <= pwdata[15:0];
        REG_GAIN_SLOW:   gain_slow_r   <= pwdata[15:0];
        REG_ANGLE_LIMIT: angle_limit_r <= pwdata[14:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_SPEED_LIMIT: prdata = {17'b0, speed_limit_r};
      REG_PWM_SCALE:   prdata = {16'b0, pwm_scale_r};
      REG_PROP_GAIN:   prdata = {16'b0, prop_gain_r};
      REG_INTEG_GAIN:  prdata = {16'b0, integ_gain_r};
      REG_ERR_THRESH:  prdata = {17'b0, err_thresh_r};
      REG_GAIN_FAST:   prdata = {16'b0, gain_fast_r};
      REG_GAIN_SLOW:   prdata = {16'b0, gain_slow_r};
      REG_ANGLE_LIMIT: prdata = {17'b0, angle_limit_r};
    endcase
  end

  // ---------------- sequencer ----------------
  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  always_comb begin
    unique case (state_r)
      ST_IDLE: state_nxt = in_xfer ? ST_S1 : ST_IDLE;
      ST_S1:   state_nxt = ST_S2;
      ST_S2:   state_nxt = ST_S3;
      ST_S3:   state_nxt = ST_S4;
      ST_S4:   state_nxt = ST_OUT;
      ST_OUT:  state_nxt = out_load ? ST_IDLE : ST_OUT;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      func_r  <= func_t'(in_func);
      speed_r <= in_speed;
      angle_r <= in_angle;
      encl_r  <= in_enc_left;
      encr_r  <= in_enc_right;
    end
  end

  always_comb begin
    ctl.s1       = (state_r == ST_S1);
    ctl.s2       = (state_r == ST_S2);
    ctl.s3       = (state_r == ST_S3);
    ctl.s4       = (state_r == ST_S4);
    ctl.do_set   = (func_r == FN_SET) && !speed_r[15];
    ctl.do_reg   = (func_r == FN_REG);
    // negative set speed behaves as stop
    ctl.do_clear = (func_r == FN_STOP) || ((func_r == FN_SET) && speed_r[15]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_en_r <= 1'b0;
    end else if (ctl.s1) begin
      if (ctl.do_clear) begin
        drive_en_r <= 1'b0;
      end else if (func_r == FN_START) begin
        drive_en_r <= 1'b1;
      end
    end
  end

  // ---------------- datapath ----------------
  ddpi_steer u_steer (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .speed        (speed_r),
    .angle        (angle_r),
    .speed_limit  (speed_limit_r),
    .angle_limit  (angle_limit_r),
    .gain_fast    (gain_fast_r),
    .gain_slow    (gain_slow_r),
    .steer_angle  (steer_angle),
    .target_left  (target_left),
    .target_right (target_right)
  );

  ddpi_lane u_lane_left (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .target          (target_left),
    .enc             (encl_r),
    .speed_limit     (speed_limit_r),
    .error_threshold (err_thresh_r),
    .prop_gain       (prop_gain_r),
    .integ_gain      (integ_gain_r),
    .pwm_scale       (pwm_scale_r),
    .actual          (act_left),
    .pwm             (pwm_left)
  );

  ddpi_lane u_lane_right (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .target          (target_right),
    .enc             (encr_r),
    .speed_limit     (speed_limit_r),
    .error_threshold (err_thresh_r),
    .prop_gain       (prop_gain_r),
    .integ_gain      (integ_gain_r),
    .pwm_scale       (pwm_scale_r),
    .actual          (act_right),
    .pwm             (pwm_right)
  );

  // ---------------- merge / output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_angle_r <= steer_angle;
      out_pwml_r  <= pwm_left;
      out_pwmr_r  <= pwm_right;
      out_mot_r   <= drive_en_r;
      out_seenl_r <= act_left;
      out_seenr_r <= act_right;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_servo_angle = out_angle_r;
  assign out_pwm_left    = out_pwml_r;
  assign out_pwm_right   = out_pwmr_r;
  assign out_motors_on   = out_mot_r;
  assign out_seen_left   = out_seenl_r;
  assign out_seen_right  = out_seenr_r;

  // ---------------- assertions ----------------
  a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> ##5 (state_r == ST_OUT))
    else $error("item did not reach the output step after four datapath steps");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && state_r == ST_IDLE))
    else $error("output load did not present a result and free the datapath");

  a_clear_motors: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.s1 && ctl.do_clear) |=> !drive_en_r)
    else $error("stop or negative speed left the motors enabled");

endmodule

`default_nettype wire

// ----- hw/rtl/ddpi_steer.sv -----
// Steering stage: angle clamp, speed clamp and left/right target derivation.
// Depends on ddpi_pkg (ctl_t, SPLIT_SPEED).
`default_nettype none

module ddpi_steer (
  input  logic                clk,
  input  logic                rst_n,
  input  ddpi_pkg::ctl_t      ctl,
  input  logic signed [15:0]  speed,
  input  logic signed [15:0]  angle,
  input  logic [14:0]         speed_limit,
  input  logic [14:0]         angle_limit,
  input  logic [15:0]         gain_fast,
  input  logic [15:0]         gain_slow,
  output logic signed [15:0]  steer_angle,
  output logic signed [17:0]  target_left,
  output logic signed [17:0]  target_right
);
  import ddpi_pkg::*;

  logic signed [15:0] steer_r, steer_nxt;
  logic signed [17:0] tl_r, tr_r;
  logic [14:0]        spd_r, spd_nxt;
  logic [15:0]        gain_r;
  logic               neg_r;
  logic [31:0]        mag1_r;
  logic [46:0]        mag2_r;

  logic signed [16:0] ang17;
  logic signed [16:0] lim17;
  logic [15:0]        abs_ang;
  logic [47:0]        rnd;
  logic [23:0]        dmag;
  logic signed [24:0] dsgn;
  logic signed [25:0] sum_l, sum_r;

  function automatic logic signed [17:0] sat18(input logic signed [25:0] v);
    logic [8:0] top;
    top = v[25:17];
    if (top == 9'h000 || top == 9'h1FF) begin
      sat18 = v[17:0];
    end else if (v[25]) begin
      sat18 = 18'sh20000;
    end else begin
      sat18 = 18'sh1FFFF;
    end
  endfunction

  // step 1: clamps
  always_comb begin
    ang17 = {angle[15], angle};
    lim17 = $signed({2'b00, angle_limit});
    if (ang17 > lim17) begin
      steer_nxt = lim17[15:0];
    end else if (ang17 < -lim17) begin
      steer_nxt = 16'(-lim17);
    end else begin
      steer_nxt = angle;
    end
    spd_nxt = (speed[14:0] > speed_limit) ? speed_limit : speed[14:0];
  end

  // step 2..4: |angle| * gain * speed, rounded half away from zero at bit 24
  always_comb begin
    abs_ang = steer_r[15] ? 16'(-steer_r) : steer_r;
    rnd     = {1'b0, mag2_r} + 48'h0000_0080_0000;
    dmag    = rnd[47:24];
    dsgn    = neg_r ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});
    sum_l   = $signed({11'b0, spd_r}) + {dsgn[24], dsgn};
    sum_r   = $signed({11'b0, spd_r}) - {dsgn[24], dsgn};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steer_r <= '0;
      tl_r    <= '0;
      tr_r    <= '0;
    end else if (ctl.s1 && ctl.do_clear) begin
      steer_r <= '0;
      tl_r    <= '0;
      tr_r    <= '0;
    end else if (ctl.do_set) begin
      if (ctl.s1 && speed != 16'sd0) begin
        steer_r <= steer_nxt;
      end
      if (ctl.s4) begin
        tl_r <= sat18(sum_l);
        tr_r <= sat18(sum_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.do_set) begin
      if (ctl.s1) begin
        spd_r  <= spd_nxt;
        gain_r <= (spd_nxt > SPLIT_SPEED) ? gain_fast : gain_slow;
      end
      if (ctl.s2) begin
        neg_r  <= steer_r[15];
        mag1_r <= abs_ang * gain_r;
      end
      if (ctl.s3) begin
        mag2_r <= mag1_r * spd_r;
      end
    end
  end

  assign steer_angle  = steer_r;
  assign target_left  = tl_r;
  assign target_right = tr_r;

endmodule

`default_nettype wire

// ----- hw/rtl/ddpi_lane.sv -----
// One wheel lane: reading capture, deadband test, PI update with saturating
// integral, command clamp and PWM scaling. Depends on ddpi_pkg (ctl_t).
`default_nettype none

module ddpi_lane (
  input  logic                clk,
  input  logic                rst_n,
  input  ddpi_pkg::ctl_t      ctl,
  input  logic signed [17:0]  target,
  input  logic signed [15:0]  enc,
  input  logic [14:0]         speed_limit,
  input  logic [14:0]         error_threshold,
  input  logic [15:0]         prop_gain,
  input  logic [15:0]         integ_gain,
  input  logic [15:0]         pwm_scale,
  output logic [14:0]         actual,
  output logic [15:0]         pwm
);
  import ddpi_pkg::*;

  logic [14:0]        actual_r, actual_nxt;
  logic [14:0]        cmd_r, cmd_nxt;
  logic signed [31:0] integ_r;
  logic signed [31:0] in_r, in_nxt;
  logic signed [18:0] err_r, err_nxt;
  logic               act_r, act_nxt;
  logic signed [35:0] ki_err_r, kp_err_r;

  logic signed [18:0] err_mag;
  logic signed [36:0] in_sum;
  logic signed [37:0] pi_sum;
  logic [29:0]        pi_shift;
  logic [30:0]        pwm_prod;
  logic [22:0]        pwm_shift;

  // step 1: clip negative reading, error and deadband
  always_comb begin
    actual_nxt = enc[15] ? 15'd0 : enc[14:0];
    err_nxt    = {target[17], target} - $signed({4'b0, actual_nxt});
    err_mag    = err_nxt[18] ? -err_nxt : err_nxt;
    act_nxt    = $unsigned(err_mag) > {4'b0, error_threshold};
  end

  // step 3: integral with 32-bit saturation
  always_comb begin
    in_sum = {{5{integ_r[31]}}, integ_r} + {ki_err_r[35], ki_err_r};
    if (in_sum[36:31] == 6'h00 || in_sum[36:31] == 6'h3F) begin
      in_nxt = in_sum[31:0];
    end else if (in_sum[36]) begin
      in_nxt = 32'sh8000_0000;
    end else begin
      in_nxt = 32'sh7FFF_FFFF;
    end
  end

  // step 4: command; inside the deadband the held command is only re-capped
  always_comb begin
    pi_sum   = {{6{in_r[31]}}, in_r} + {{2{kp_err_r[35]}}, kp_err_r};
    pi_shift = pi_sum[37:8];
    if (act_r) begin
      if (pi_sum[37] || pi_sum == 38'sd0) begin
        cmd_nxt = 15'd0;
      end else if (pi_shift > {15'b0, speed_limit}) begin
        cmd_nxt = speed_limit;
      end else begin
        cmd_nxt = pi_shift[14:0];
      end
    end else begin
      cmd_nxt = (cmd_r > speed_limit) ? speed_limit : cmd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      actual_r <= '0;
      cmd_r    <= '0;
      integ_r  <= '0;
    end else if (ctl.s1 && ctl.do_clear) begin
      actual_r <= '0;
      cmd_r    <= '0;
      integ_r  <= '0;
    end else if (ctl.do_reg) begin
      if (ctl.s1) begin
        actual_r <= actual_nxt;
      end
      if (ctl.s4) begin
        cmd_r <= cmd_nxt;
        if (act_r) begin
          integ_r <= in_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.do_reg) begin
      if (ctl.s1) begin
        err_r <= err_nxt;
        act_r <= act_nxt;
      end
      if (ctl.s2) begin
        ki_err_r <= $signed({1'b0, integ_gain}) * err_r;
        kp_err_r <= $signed({1'b0, prop_gain}) * err_r;
      end
      if (ctl.s3) begin
        in_r <= in_nxt;
      end
    end
  end

  // PWM from the held command, saturated to 16 bits
  always_comb begin
    pwm_prod  = cmd_r * pwm_scale;
    pwm_shift = pwm_prod[30:8];
    pwm       = (pwm_shift[22:16] != 7'd0) ? 16'hFFFF : pwm_shift[15:0];
  end

  assign actual = actual_r;

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench for the differential drive PI speed controller.
// Depends on ddpi_pkg and differential_drive_pi_speed_control; compares every result
// with a built-in predictor or table entry as registers, traffic and stalls vary.
module tb;
  import ddpi_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int PHASE_ITEMS = 200;

  typedef struct packed {
    func_t       func;
    logic [15:0] speed;
    logic [15:0] angle;
    logic [15:0] enc_l;
    logic [15:0] enc_r;
  } cmd_item_t;

  typedef struct packed {
    logic [15:0] servo;
    logic [15:0] pwm_l;
    logic [15:0] pwm_r;
    logic        motors;
    logic [14:0] seen_l;
    logic [14:0] seen_r;
  } drive_status_t;

  typedef struct packed {
    cmd_item_t     item;
    logic          fixed;
    drive_status_t want;
  } cmd_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_func = 2'd0;
  logic [15:0] in_speed = '0;
  logic [15:0] in_angle = '0;
  logic [15:0] in_enc_left = '0;
  logic [15:0] in_enc_right = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_servo_angle;
  logic [15:0] out_pwm_left;
  logic [15:0] out_pwm_right;
  logic        out_motors_on;
  logic [14:0] out_seen_left;
  logic [14:0] out_seen_right;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  differential_drive_pi_speed_control u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_speed       (in_speed),
    .in_angle       (in_angle),
    .in_enc_left    (in_enc_left),
    .in_enc_right   (in_enc_right),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_servo_angle(out_servo_angle),
    .out_pwm_left   (out_pwm_left),
    .out_pwm_right  (out_pwm_right),
    .out_motors_on  (out_motors_on),
    .out_seen_left  (out_seen_left),
    .out_seen_right (out_seen_right),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #5 clk = ~clk;

  // predictor: register copies and controller state
  logic [14:0]        lim_speed;
  logic [15:0]        pwm_k, kp, ki, k_fast, k_slow;
  logic [14:0]        deadband, lim_angle;
  logic signed [15:0] steer_q;
  logic signed [17:0] tgt_l, tgt_r;
  logic [15:0]        meas_l, meas_r, cmd_l, cmd_r;
  logic signed [31:0] integ_l, integ_r;
  logic               drive_on;

  drive_status_t pending_status[$];
  int            errors = 0;
  int            stall_cycles = 0;
  int            burst_left = 0;
  int            rx_cycle = 0;
  int            rx_mode = 0;

  function automatic longint clampl(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void clear_state();
    steer_q = '0;
    tgt_l = '0;
    tgt_r = '0;
    meas_l = '0;
    meas_r = '0;
    cmd_l = '0;
    cmd_r = '0;
    integ_l = '0;
    integ_r = '0;
    drive_on = 1'b0;
  endfunction

  function automatic void pi_wheel(input logic signed [17:0] tgt, input logic [15:0] act,
                                   inout logic signed [31:0] integ, inout logic [15:0] cmd);
    longint err, mag, acc, sum;
    err = longint'(tgt) - longint'(act);
    mag = err < 0 ? -err : err;
    if (mag > longint'(deadband)) begin
      acc = clampl(longint'(integ) + longint'(ki) * err, -64'sd2147483648, 64'sd2147483647);
      integ = 32'(acc);
      sum = longint'(kp) * err + acc;
      if (sum <= 0) cmd = '0;
      else cmd = 16'(clampl(sum >>> 8, 0, longint'(lim_speed)));
    end
    // a held command above a lowered limit is cut back on the next tick
    if (longint'(cmd) > longint'(lim_speed)) cmd = 16'(lim_speed);
  endfunction

  function automatic logic [15:0] to_pwm(input logic [15:0] c);
    longint p;
    p = (longint'(c) * longint'(pwm_k)) >> 8;
    return p > 65535 ? 16'hFFFF : 16'(p);
  endfunction

  function automatic drive_status_t drive_step(input cmd_item_t it);
    longint        spd, p, mag, d;
    logic [15:0]   g;
    drive_status_t st;
    case (it.func)
      FN_SET: begin
        spd = longint'($signed(it.speed));
        if (spd != 0)
          steer_q = 16'(clampl(longint'($signed(it.angle)), -longint'(lim_angle),
                               longint'(lim_angle)));
        if (spd < 0) begin
          clear_state();
        end else begin
          if (spd > longint'(lim_speed)) spd = longint'(lim_speed);
          g = (spd > longint'(SPLIT_SPEED)) ? k_fast : k_slow;
          p = longint'(steer_q) * longint'(g) * spd;
          mag = p < 0 ? -p : p;
          d = (mag + (64'sd1 <<< 23)) >>> 24;
          if (p < 0) d = -d;
          tgt_l = 18'(clampl(spd + d, -131072, 131071));
          tgt_r = 18'(clampl(spd - d, -131072, 131071));
        end
      end
      FN_REG: begin
        meas_l = $signed(it.enc_l) < 0 ? 16'd0 : it.enc_l;
        meas_r = $signed(it.enc_r) < 0 ? 16'd0 : it.enc_r;
        pi_wheel(tgt_l, meas_l, integ_l, cmd_l);
        pi_wheel(tgt_r, meas_r, integ_r, cmd_r);
      end
      FN_STOP: clear_state();
      default: drive_on = 1'b1;
    endcase
    st.servo = steer_q;
    st.pwm_l = to_pwm(cmd_l);
    st.pwm_r = to_pwm(cmd_r);
    st.motors = drive_on;
    st.seen_l = meas_l[14:0];
    st.seen_r = meas_r[14:0];
    return st;
  endfunction

  function automatic logic [15:0] enc_near(input logic signed [17:0] t);
    longint v;
    v = longint'(t) + longint'($urandom_range(0, 128)) - 64;
    return 16'(clampl(v, -32768, 32767));
  endfunction

  function automatic cmd_item_t rand_item();
    cmd_item_t it;
    int        pick;
    it.speed = 16'($urandom);
    it.angle = 16'($urandom);
    it.enc_l = 16'($urandom);
    it.enc_r = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      it.func = FN_START;
    end else if (pick < 9) begin
      it.func = FN_STOP;
    end else if (pick < 34) begin
      it.func = FN_SET;
      case ($urandom_range(0, 9))
        0: ;
        1: begin
          case ($urandom_range(0, 4))
            0: it.speed = 16'd0;
            1: it.speed = 16'd1800;
            2: it.speed = 16'd1801;
            3: it.speed = 16'd32767;
            default: it.speed = 16'hFFFF;
          endcase
        end
        default: it.speed = 16'($urandom_range(0, 3000));
      endcase
      if ($urandom_range(0, 1) == 0) it.angle = 16'($urandom_range(0, 8000)) - 16'd4000;
    end else begin
      it.func = FN_REG;
      // mostly readings near the targets so the deadband and the PI path both run
      if ($urandom_range(0, 9) < 7) begin
        it.enc_l = enc_near(tgt_l);
        it.enc_r = enc_near(tgt_r);
      end
    end
    return it;
  endfunction

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_SPEED_LIMIT: lim_speed = val[14:0];
      REG_PWM_SCALE:   pwm_k = val[15:0];
      REG_PROP_GAIN:   kp = val[15:0];
      REG_INTEG_GAIN:  ki = val[15:0];
      REG_ERR_THRESH:  deadband = val[14:0];
      REG_GAIN_FAST:   k_fast = val[15:0];
      REG_GAIN_SLOW:   k_slow = val[15:0];
      default:         lim_angle = val[14:0];
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic program_regs(input int lim, input int scale, input int p_gain, input int i_gain,
                              input int thr, input int g_fast, input int g_slow, input int alim);
    reg_write(REG_SPEED_LIMIT, 32'(lim));
    reg_write(REG_PWM_SCALE, 32'(scale));
    reg_write(REG_PROP_GAIN, 32'(p_gain));
    reg_write(REG_INTEG_GAIN, 32'(i_gain));
    reg_write(REG_ERR_THRESH, 32'(thr));
    reg_write(REG_GAIN_FAST, 32'(g_fast));
    reg_write(REG_GAIN_SLOW, 32'(g_slow));
    reg_write(REG_ANGLE_LIMIT, 32'(alim));
  endtask

  // one input transfer, with bursts and random gaps in front of it
  task automatic send_item(input cmd_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    in_func = it.func;
    in_speed = it.speed;
    in_angle = it.angle;
    in_enc_left = it.enc_l;
    in_enc_right = it.enc_r;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic report(input string fld, input longint want, input longint got);
    errors++;
    $display("%0t: %s expected %0d got %0d", $time, fld, want, got);
  endtask

  // receiver stall pattern, periodically switching mode
  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 97 == 0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (rx_cycle % 5 == 0);
      default: out_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk) begin
    drive_status_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_status.size() == 0) begin
        errors++;
        $display("%0t: result transfer with nothing expected", $time);
      end else begin
        want = pending_status.pop_front();
        if (out_servo_angle !== want.servo)
          report("servo_angle", longint'($signed(want.servo)), longint'($signed(out_servo_angle)));
        if (out_pwm_left !== want.pwm_l) report("pwm_left", want.pwm_l, out_pwm_left);
        if (out_pwm_right !== want.pwm_r) report("pwm_right", want.pwm_r, out_pwm_right);
        if (out_motors_on !== want.motors) report("motors_on", want.motors, out_motors_on);
        if (out_seen_left !== want.seen_l) report("seen_left", want.seen_l, out_seen_left);
        if (out_seen_right !== want.seen_r) report("seen_right", want.seen_r, out_seen_right);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || psel || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  initial begin
    cmd_row_t      dir_rows [0:23];
    cmd_item_t     it;
    drive_status_t st;
    bit            wide;
    dir_rows = '{
      '{'{FN_STOP,  16'd0,     16'd0,     16'd0,     16'd0},     1'b1,
        '{16'd0, 16'd0, 16'd0, 1'b0, 15'd0, 15'd0}},
      '{'{FN_START, 16'd0,     16'd0,     16'd0,     16'd0},     1'b1,
        '{16'd0, 16'd0, 16'd0, 1'b1, 15'd0, 15'd0}},
      // zero speed leaves the angle alone
      '{'{FN_SET,   16'd0,     16'd100,   16'd0,     16'd0},     1'b1,
        '{16'd0, 16'd0, 16'd0, 1'b1, 15'd0, 15'd0}},
      '{'{FN_SET,   16'd32767, 16'd32767, 16'd0,     16'd0},     1'b0, '0},
      '{'{FN_REG,   16'd0,     16'd0,     16'h8000,  16'd0},     1'b0, '0},
      '{'{FN_REG,   16'd0,     16'd0,     16'd32767, 16'd32767}, 1'b0, '0},
      '{'{FN_SET,   16'd1800,  16'h8000,  16'd0,     16'd0},     1'b0, '0},
      '{'{FN_REG,   16'd0,     16'd0,     16'd100,   16'd3000},  1'b0, '0},
      '{'{FN_SET,   16'd1801,  16'd256,   16'd0,     16'd0},     1'b0, '0},
      '{'{FN_REG,   16'd0,     16'd0,     16'd1700,  16'd1900},  1'b0, '0},
      '{'{FN_REG,   16'd0,     16'd0,     16'd1801,  16'd1801},  1'b0, '0},
      '{'{FN_SET,   16'd0,     -16'sd5000, 16'd0,    16'd0},     1'b0, '0},
      '{'{FN_REG,   16'd0,     16'd0,     16'd0,     16'd0},     1'b0, '0},
      // negative speed clears everything, angle included
      '{'{FN_SET,   16'hFFFF,  16'd500,   16'd0,     16'd0},     1'b1,
        '{16'd0, 16'd0, 16'd0, 1'b0, 15'd0, 15'd0}},
      '{'{FN_REG,   16'd0,     16'd0,     16'd5,     16'd5},     1'b1,
        '{16'd0, 16'd0, 16'd0, 1'b0, 15'd5, 15'd5}},
      '{'{FN_START, 16'd0,     16'd0,     16'd0,     16'd0},     1'b1,
        '{16'd0, 16'd0, 16'd0, 1'b1, 15'd5, 15'd5}},
      '{'{FN_SET,   16'd100,   -16'sd100, 16'd0,     16'd0},     1'b0, '0},
      '{'{FN_REG,   16'd0,     16'd0,     16'd0,     16'd32767}, 1'b0, '0},
      '{'{FN_REG,   16'd0,     16'd0,     16'hFFFF,  16'd1},     1'b0, '0},
      '{'{FN_SET,   16'h8000,  16'h8000,  16'd0,     16'd0},     1'b1,
        '{16'd0, 16'd0, 16'd0, 1'b0, 15'd0, 15'd0}},
      '{'{FN_START, 16'd0,     16'd0,     16'd0,     16'd0},     1'b1,
        '{16'd0, 16'd0, 16'd0, 1'b1, 15'd0, 15'd0}},
      '{'{FN_SET,   16'd2000,  16'd1000,  16'd0,     16'd0},     1'b0, '0},
      '{'{FN_REG,   16'd0,     16'd0,     16'd1000,  16'd3000},  1'b0, '0},
      '{'{FN_STOP,  16'd0,     16'd0,     16'd0,     16'd0},     1'b1,
        '{16'd0, 16'd0, 16'd0, 1'b0, 15'd0, 15'd0}}
    };
    lim_speed = 15'd32767;
    pwm_k = 16'd256;
    kp = '0;
    ki = '0;
    deadband = '0;
    k_fast = '0;
    k_slow = '0;
    lim_angle = 15'd7680;
    clear_state();
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // big gains so target and integral saturation show up early
    program_regs(32767, 65535, 256, 65535, 20, 65535, 1000, 32767);
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].item);
      st = drive_step(dir_rows[i].item);
      pending_status.push_back(dir_rows[i].fixed ? dir_rows[i].want : st);
    end

    for (int ph = 0; ph < 8; ph++) begin
      settle();
      if (ph == 0) begin
        program_regs(32767, 65535, 65535, 65535, 32767, 65535, 65535, 32767);
      end else if (ph == 1) begin
        program_regs(0, 0, 0, 0, 0, 0, 0, 0);
      end else begin
        wide = ($urandom_range(0, 3) == 0);
        program_regs(wide ? $urandom_range(0, 32767) : $urandom_range(500, 4000),
                     wide ? $urandom_range(0, 65535) : $urandom_range(64, 1024),
                     wide ? $urandom_range(0, 65535) : $urandom_range(0, 1024),
                     wide ? $urandom_range(0, 65535) : $urandom_range(0, 128),
                     wide ? $urandom_range(0, 32767) : $urandom_range(0, 50),
                     wide ? $urandom_range(0, 65535) : $urandom_range(0, 2000),
                     wide ? $urandom_range(0, 65535) : $urandom_range(0, 2000),
                     wide ? $urandom_range(0, 32767) : $urandom_range(0, 10000));
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        it = rand_item();
        send_item(it);
        pending_status.push_back(drive_step(it));
      end
    end

    settle();
    if (errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/ddpi_pkg.sv
hw/rtl/ddpi_steer.sv
hw/rtl/ddpi_lane.sv
hw/rtl/differential_drive_pi_speed_control.sv
sim/tb.sv
